[rtl/core/obwb_pkg.sv]
package obwb_pkg;

  localparam int CoordW  = 32;
  localparam int ScaleW  = 16;
  localparam int QuatW   = 16;
  localparam int ProdW   = CoordW + ScaleW;       // coordinate times scale factor
  localparam int ScaledW = 40;                    // scaled coordinate, Q.16
  localparam int QProdW  = 2 * QuatW;             // quaternion component product, Q.30
  localparam int MatSumW = QProdW + 2;            // matrix entry before rounding, Q.30
  localparam int MatW    = 19;                    // matrix entry, Q.15
  localparam int TermW   = MatW + ScaledW;        // one row term, Q.31
  localparam int AccW    = TermW + 2;             // sum of three terms, Q.31
  localparam int InW     = 400;
  localparam int OutW    = 192;

  typedef logic signed [CoordW-1:0]  coord_t;
  typedef logic signed [ScaleW-1:0]  scale_t;
  typedef logic signed [QuatW-1:0]   quat_t;
  typedef logic signed [ProdW-1:0]   prod_t;
  typedef logic signed [ScaledW-1:0] scaled_t;
  typedef logic signed [QProdW-1:0]  qprod_t;
  typedef logic signed [MatSumW-1:0] matsum_t;
  typedef logic signed [MatW-1:0]    mat_t;
  typedef logic signed [TermW-1:0]   term_t;
  typedef logic signed [AccW-1:0]    acc_t;

  // per-stage load enables of the axis reduction
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } adv_t;

  // round half up from Q.24 to Q.16
  function automatic scaled_t round_scaled(input prod_t p);
    prod_t t;
    begin
      t = p + prod_t'(128);
      return scaled_t'(t[ProdW-1:8]);
    end
  endfunction

  // round half up from Q.30 to Q.15
  function automatic mat_t round_mat(input matsum_t v);
    matsum_t t;
    begin
      t = v + matsum_t'(16384);
      return mat_t'(t[MatSumW-1:15]);
    end
  endfunction

endpackage

[rtl/core/obwb_axis.sv]
// Bounds of one world axis: a row of the rotation applied to the box extent.
// The rounding, translation and saturation after the dot product are monotone,
// so the least corner is the sum of the per-column smaller terms, and likewise
// for the greatest.
module obwb_axis (
  input  logic               clk,
  input  obwb_pkg::adv_t     adv,
  input  obwb_pkg::mat_t     row [3],
  input  obwb_pkg::scaled_t  lo  [3],
  input  obwb_pkg::scaled_t  hi  [3],
  input  obwb_pkg::coord_t   sh,
  output obwb_pkg::coord_t   bound_min,
  output obwb_pkg::coord_t   bound_max
);

  localparam int RndW = obwb_pkg::AccW - 15;
  localparam int SumW = RndW + 1;

  obwb_pkg::term_t  term_lo [3];
  obwb_pkg::term_t  term_hi [3];
  obwb_pkg::coord_t sh3;
  obwb_pkg::term_t  small_t [3];
  obwb_pkg::term_t  large_t [3];
  obwb_pkg::coord_t sh4;
  obwb_pkg::acc_t   acc_min;
  obwb_pkg::acc_t   acc_max;
  obwb_pkg::coord_t sh5;

  obwb_pkg::acc_t   rnd_min_full;
  obwb_pkg::acc_t   rnd_max_full;
  logic signed [SumW-1:0] w_min;
  logic signed [SumW-1:0] w_max;
  obwb_pkg::coord_t sat_min;
  obwb_pkg::coord_t sat_max;

  // stage 3: row terms at both ends of each column
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      for (int j = 0; j < 3; j++) begin
        term_lo[j] <= obwb_pkg::term_t'(row[j]) * obwb_pkg::term_t'(lo[j]);
        term_hi[j] <= obwb_pkg::term_t'(row[j]) * obwb_pkg::term_t'(hi[j]);
      end
      sh3 <= sh;
    end
  end

  // stage 4: order each pair
  always_ff @(posedge clk) begin
    if (adv.s4) begin
      for (int j = 0; j < 3; j++) begin
        small_t[j] <= (term_lo[j] < term_hi[j]) ? term_lo[j] : term_hi[j];
        large_t[j] <= (term_lo[j] < term_hi[j]) ? term_hi[j] : term_lo[j];
      end
      sh4 <= sh3;
    end
  end

  // stage 5: extreme dot products
  always_ff @(posedge clk) begin
    if (adv.s5) begin
      acc_min <= obwb_pkg::acc_t'(small_t[0]) + obwb_pkg::acc_t'(small_t[1])
               + obwb_pkg::acc_t'(small_t[2]);
      acc_max <= obwb_pkg::acc_t'(large_t[0]) + obwb_pkg::acc_t'(large_t[1])
               + obwb_pkg::acc_t'(large_t[2]);
      sh5 <= sh4;
    end
  end

  // stage 6: round to Q.16, translate, saturate
  always_comb begin
    rnd_min_full = acc_min + obwb_pkg::acc_t'(16384);
    rnd_max_full = acc_max + obwb_pkg::acc_t'(16384);
    w_min = SumW'($signed(rnd_min_full[obwb_pkg::AccW-1:15])) + SumW'(sh5);
    w_max = SumW'($signed(rnd_max_full[obwb_pkg::AccW-1:15])) + SumW'(sh5);
    if (w_min > SumW'(32'sh7fffffff)) begin
      sat_min = 32'sh7fffffff;
    end else if (w_min < SumW'(32'sh80000000)) begin
      sat_min = 32'sh80000000;
    end else begin
      sat_min = w_min[obwb_pkg::CoordW-1:0];
    end
    if (w_max > SumW'(32'sh7fffffff)) begin
      sat_max = 32'sh7fffffff;
    end else if (w_max < SumW'(32'sh80000000)) begin
      sat_max = 32'sh80000000;
    end else begin
      sat_max = w_max[obwb_pkg::CoordW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s6) begin
      bound_min <= sat_min;
      bound_max <= sat_max;
    end
  end

endmodule

[rtl/core/oriented_box_world_bounds_top.sv]
// channel | dir | tdata fields, lowest bit first
// s_*     | in  | box_min_x/y/z, box_max_x/y/z (32 each), scale_xyz (48),
//         |     | rotation_quat (64), shift_x/y/z (32 each): 400 bits
// m_*     | out | world_min_x/y/z, world_max_x/y/z (32 each): 192 bits
//
// One word in and one result word out per cycle while m_tready is high.
// The accepting edge loads stage 1; m_tvalid rises once stage 6 holds the
// word. The six register stages are set by the multiplier chain: scale and
// quaternion products, rounding, row terms, pair ordering, three-term sum,
// final round and saturate (stage 6 is the output register).
// Synchronous active-high reset clears the stage valid bits and the check counter only.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up and a stalled m_tready never drops or repeats a word.
module oriented_box_world_bounds_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
  // scale_xyz, rotation_quat, shift_x, shift_y, shift_z
  input  logic [obwb_pkg::InW-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // world_min_x, world_min_y, world_min_z, world_max_x, world_max_y, world_max_z
  output logic [obwb_pkg::OutW-1:0]  m_tdata
);

  localparam obwb_pkg::matsum_t MatOneQ30 = obwb_pkg::matsum_t'(34'sd1073741824);
  localparam obwb_pkg::mat_t    MatOneQ15 = obwb_pkg::mat_t'(19'sd32768);

  logic [6:1] v;
  logic [6:1] en;
  obwb_pkg::adv_t adv;
  logic [2:0] occ;

  // unpacked input word
  obwb_pkg::coord_t box_min [3];
  obwb_pkg::coord_t box_max [3];
  obwb_pkg::scale_t scale_f [3];
  obwb_pkg::coord_t shift_in [3];
  obwb_pkg::quat_t  qw, qx, qy, qz;

  // stage 1
  obwb_pkg::prod_t  p_lo [3];
  obwb_pkg::prod_t  p_hi [3];
  obwb_pkg::qprod_t q_xx, q_yy, q_zz, q_xy, q_xz, q_yz, q_wx, q_wy, q_wz;
  obwb_pkg::coord_t sh1 [3];

  // stage 2
  obwb_pkg::scaled_t lo2 [3];
  obwb_pkg::scaled_t hi2 [3];
  obwb_pkg::mat_t    rm2 [3][3];
  obwb_pkg::coord_t  sh2 [3];
  obwb_pkg::matsum_t ms  [3][3];

  obwb_pkg::coord_t bmin [3];
  obwb_pkg::coord_t bmax [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      box_min[a]  = s_tdata[32*a +: 32];
      box_max[a]  = s_tdata[96 + 32*a +: 32];
      scale_f[a]  = s_tdata[192 + 16*a +: 16];
      shift_in[a] = s_tdata[304 + 32*a +: 32];
    end
    qz = s_tdata[255:240];
    qy = s_tdata[271:256];
    qx = s_tdata[287:272];
    qw = s_tdata[303:288];
  end

  // stall chain: a stage loads when empty or when its successor loads
  always_comb begin
    en[6] = !v[6] || m_tready;
    for (int k = 5; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
    adv = '{s3: en[3], s4: en[4], s5: en[5], s6: en[6]};
  end

  assign s_tready = en[1];
  assign m_tvalid = v[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= s_tvalid;
      end
      for (int k = 2; k <= 6; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 1: scale products and quaternion products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int a = 0; a < 3; a++) begin
        p_lo[a] <= obwb_pkg::prod_t'(box_min[a]) * obwb_pkg::prod_t'(scale_f[a]);
        p_hi[a] <= obwb_pkg::prod_t'(box_max[a]) * obwb_pkg::prod_t'(scale_f[a]);
        sh1[a]  <= shift_in[a];
      end
      q_xx <= obwb_pkg::qprod_t'(qx) * obwb_pkg::qprod_t'(qx);
      q_yy <= obwb_pkg::qprod_t'(qy) * obwb_pkg::qprod_t'(qy);
      q_zz <= obwb_pkg::qprod_t'(qz) * obwb_pkg::qprod_t'(qz);
      q_xy <= obwb_pkg::qprod_t'(qx) * obwb_pkg::qprod_t'(qy);
      q_xz <= obwb_pkg::qprod_t'(qx) * obwb_pkg::qprod_t'(qz);
      q_yz <= obwb_pkg::qprod_t'(qy) * obwb_pkg::qprod_t'(qz);
      q_wx <= obwb_pkg::qprod_t'(qw) * obwb_pkg::qprod_t'(qx);
      q_wy <= obwb_pkg::qprod_t'(qw) * obwb_pkg::qprod_t'(qy);
      q_wz <= obwb_pkg::qprod_t'(qw) * obwb_pkg::qprod_t'(qz);
    end
  end

  // quaternion to matrix in Q.30, no normalization
  always_comb begin
    ms[0][0] = MatOneQ30 - ((obwb_pkg::matsum_t'(q_yy) + obwb_pkg::matsum_t'(q_zz)) <<< 1);
    ms[0][1] = (obwb_pkg::matsum_t'(q_xy) - obwb_pkg::matsum_t'(q_wz)) <<< 1;
    ms[0][2] = (obwb_pkg::matsum_t'(q_xz) + obwb_pkg::matsum_t'(q_wy)) <<< 1;
    ms[1][0] = (obwb_pkg::matsum_t'(q_xy) + obwb_pkg::matsum_t'(q_wz)) <<< 1;
    ms[1][1] = MatOneQ30 - ((obwb_pkg::matsum_t'(q_xx) + obwb_pkg::matsum_t'(q_zz)) <<< 1);
    ms[1][2] = (obwb_pkg::matsum_t'(q_yz) - obwb_pkg::matsum_t'(q_wx)) <<< 1;
    ms[2][0] = (obwb_pkg::matsum_t'(q_xz) - obwb_pkg::matsum_t'(q_wy)) <<< 1;
    ms[2][1] = (obwb_pkg::matsum_t'(q_yz) + obwb_pkg::matsum_t'(q_wx)) <<< 1;
    ms[2][2] = MatOneQ30 - ((obwb_pkg::matsum_t'(q_xx) + obwb_pkg::matsum_t'(q_yy)) <<< 1);
  end

  // stage 2: round scaled extent to Q.16 and matrix to Q.15
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int a = 0; a < 3; a++) begin
        lo2[a] <= obwb_pkg::round_scaled(p_lo[a]);
        hi2[a] <= obwb_pkg::round_scaled(p_hi[a]);
        sh2[a] <= sh1[a];
        for (int j = 0; j < 3; j++) begin
          rm2[a][j] <= obwb_pkg::round_mat(ms[a][j]);
        end
      end
    end
  end

  // stages 3 to 6: one reduction per world axis
  for (genvar a = 0; a < 3; a++) begin : g_axis
    obwb_axis u_axis (
      .clk       (clk),
      .adv       (adv),
      .row       (rm2[a]),
      .lo        (lo2),
      .hi        (hi2),
      .sh        (sh2[a]),
      .bound_min (bmin[a]),
      .bound_max (bmax[a])
    );
  end

  assign m_tdata = {bmax[2], bmax[1], bmax[0], bmin[2], bmin[1], bmin[0]};

  // words in flight, tracked for the checks below
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + 3'(s_tvalid && s_tready) - 3'(m_tvalid && m_tready);
    end
  end

  a_occupancy : assert property (@(posedge clk) disable iff (rst)
    32'(occ) == $countones(v))
    else $error("words in flight disagree with stage valid bits");

  a_hold_under_stall : assert property (@(posedge clk) disable iff (rst)
    (v[6] && !m_tready && v[5]) |=> v[5])
    else $error("stage 5 word lost while output stalled");

  a_zero_quat_identity : assert property (@(posedge clk) disable iff (rst)
    (v[1] && en[2] && q_xx == '0 && q_yy == '0 && q_zz == '0) |=>
      (rm2[0][0] == MatOneQ15 && rm2[1][1] == MatOneQ15 && rm2[2][2] == MatOneQ15))
    else $error("zero rotation does not give unit diagonal");

  a_min_le_max : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (bmin[0] <= bmax[0] && bmin[1] <= bmax[1] && bmin[2] <= bmax[2]))
    else $error("world minimum above world maximum");

endmodule

[tb/tb_top.sv]
module tb_top;

  // Input word, packed so that the first field sits in the lowest bits of s_tdata:
  // box_min x/y/z, box_max x/y/z, scale x/y/z (Q8.8), quat z/y/x/w (Q1.15), shift x/y/z.
  typedef struct packed {
    obwb_pkg::coord_t [2:0] shift;
    obwb_pkg::quat_t  [3:0] quat;     // [3] = w, [2] = x, [1] = y, [0] = z
    obwb_pkg::scale_t [2:0] scale;
    obwb_pkg::coord_t [2:0] box_max;
    obwb_pkg::coord_t [2:0] box_min;
  } box_word_t;

  // Result word: world_min x/y/z in [0..2], world_max x/y/z in [3..5].
  typedef obwb_pkg::coord_t [5:0] bounds_t;

  typedef struct {
    box_word_t word;
    bit        typed;   // expected bounds written out by hand
    bounds_t   want;
  } dir_row_t;

  localparam obwb_pkg::coord_t ONE   = 32'sh0001_0000;
  localparam obwb_pkg::coord_t C_MAX = 32'sh7FFF_FFFF;
  localparam obwb_pkg::coord_t C_MIN = 32'sh8000_0000;
  localparam logic [47:0] UNIT_SCALE = {3{16'h0100}};
  localparam logic [47:0] NEG_SCALE  = {3{16'hFF00}};
  localparam logic [47:0] HALF_SCALE = {3{16'h0080}};
  localparam logic [63:0] NO_QUAT    = 64'h0;
  localparam logic [63:0] QUAT_Z90   = {16'h5A82, 16'h0000, 16'h0000, 16'h5A82};
  localparam logic [63:0] QUAT_Y90   = {16'h5A82, 16'h0000, 16'h5A82, 16'h0000};
  localparam logic [63:0] QUAT_X180  = {16'h0000, 16'h7FFF, 16'h0000, 16'h0000};
  localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SAT_LO = -SAT_HI - 1;
  localparam int RANDOM_WORDS = 950;
  localparam int CALM_TAIL    = 100;   // final words run with no idling at all

  logic           clk;
  logic           rst;
  logic           s_tvalid;
  logic           s_tready;
  logic [obwb_pkg::InW-1:0]  s_tdata;  // box_min x/y/z, box_max x/y/z, scale, quat, shift
  logic           m_tvalid;
  logic           m_tready;
  logic [obwb_pkg::OutW-1:0] m_tdata;  // world_min x/y/z, world_max x/y/z

  bounds_t  bounds_due [$];  // predicted results, oldest first
  dir_row_t dir_rows [$];
  bit       idle_on;
  int       mismatches;
  int       words_sent;
  int       words_checked;
  string    field_name [6] = '{"world_min_x", "world_min_y", "world_min_z",
                               "world_max_x", "world_max_y", "world_max_z"};

  oriented_box_world_bounds_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run (every word behind the longest
  // source gap and the longest sink stall).
  initial begin
    #2_000_000;
    $display("tb_top: timeout with %0d results outstanding", bounds_due.size());
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input int word_no,
                                 input obwb_pkg::coord_t got, input obwb_pkg::coord_t want);
    $display("tb_top: mismatch on result %0d, %s: got %h, want %h",
             word_no, what, got, want);
    mismatches++;
  endtask

  // Round half up: floor((v + half LSB) / 2^k); >>> on a signed longint floors.
  function automatic longint round_half_up(input longint v, input int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  // Predict the world-space bounds of one box word.
  function automatic bounds_t world_bounds(input box_word_t w);
    longint lo [3], hi [3], sh [3], pt [3], mn [3], mx [3];
    longint rot [3][3];
    longint qw, qx, qy, qz, fac, v, acc, one;
    obwb_pkg::coord_t c32;
    obwb_pkg::scale_t s16;
    obwb_pkg::quat_t  q16;
    int a, c;
    bounds_t b;
    // scale both box extremes into Q.16, no saturation
    for (a = 0; a < 3; a++) begin
      s16 = w.scale[a];
      fac = s16;
      c32 = w.box_min[a];
      v = c32;
      lo[a] = round_half_up(v * fac, 8);
      c32 = w.box_max[a];
      v = c32;
      hi[a] = round_half_up(v * fac, 8);
      c32 = w.shift[a];
      sh[a] = c32;
    end
    q16 = w.quat[3]; qw = q16;
    q16 = w.quat[2]; qx = q16;
    q16 = w.quat[1]; qy = q16;
    q16 = w.quat[0]; qz = q16;
    // rotation matrix, exact in Q.30, rounded to Q.15; no normalization
    one = longint'(1) << 30;
    rot[0][0] = round_half_up(one - 2 * (qy * qy + qz * qz), 15);
    rot[0][1] = round_half_up(2 * (qx * qy - qw * qz), 15);
    rot[0][2] = round_half_up(2 * (qx * qz + qw * qy), 15);
    rot[1][0] = round_half_up(2 * (qx * qy + qw * qz), 15);
    rot[1][1] = round_half_up(one - 2 * (qx * qx + qz * qz), 15);
    rot[1][2] = round_half_up(2 * (qy * qz - qw * qx), 15);
    rot[2][0] = round_half_up(2 * (qx * qz - qw * qy), 15);
    rot[2][1] = round_half_up(2 * (qy * qz + qw * qx), 15);
    rot[2][2] = round_half_up(one - 2 * (qx * qx + qy * qy), 15);
    // walk the eight corners, keep the running extremes per axis
    for (c = 0; c < 8; c++) begin
      pt[0] = c[0] ? hi[0] : lo[0];
      pt[1] = c[1] ? hi[1] : lo[1];
      pt[2] = c[2] ? hi[2] : lo[2];
      for (a = 0; a < 3; a++) begin
        acc = rot[a][0] * pt[0] + rot[a][1] * pt[1] + rot[a][2] * pt[2];
        v = round_half_up(acc, 15) + sh[a];
        if (v > SAT_HI) v = SAT_HI;
        else if (v < SAT_LO) v = SAT_LO;
        if (c == 0 || v < mn[a]) mn[a] = v;
        if (c == 0 || v > mx[a]) mx[a] = v;
      end
    end
    for (a = 0; a < 3; a++) begin
      b[a]     = obwb_pkg::coord_t'(mn[a]);
      b[3 + a] = obwb_pkg::coord_t'(mx[a]);
    end
    return b;
  endfunction

  function automatic box_word_t box_word(input obwb_pkg::coord_t mnx, mny, mnz, mxx, mxy, mxz,
                                         input logic [47:0] scl, input logic [63:0] q,
                                         input obwb_pkg::coord_t sx, sy, sz);
    box_word_t w;
    w.box_min = {mnz, mny, mnx};
    w.box_max = {mxz, mxy, mxx};
    w.scale   = scl;
    w.quat    = q;
    w.shift   = {sz, sy, sx};
    return w;
  endfunction

  function automatic bounds_t expect_bounds(input obwb_pkg::coord_t mnx, mny, mnz,
                                            mxx, mxy, mxz);
    return {mxz, mxy, mxx, mnz, mny, mnx};
  endfunction

  // Mostly plausible scene boxes: ordered extents, moderate scale, a normalized
  // quaternion. A quarter of the words are raw noise to toggle every bit.
  function automatic box_word_t random_word(input bit wild);
    box_word_t w;
    logic [415:0] raw;
    real qv [4];
    real norm;
    int a, ctr, half;
    if (wild) begin
      for (a = 0; a < 13; a++) raw[32*a +: 32] = $urandom;
      return box_word_t'(raw[obwb_pkg::InW-1:0]);
    end
    for (a = 0; a < 3; a++) begin
      ctr  = int'($urandom_range(0, 1 << 24)) - (1 << 23);
      half = int'($urandom_range(0, 1 << 21));
      w.box_min[a] = ctr - half;
      w.box_max[a] = ctr + half;
      if ($urandom_range(0, 3) == 0) w.scale[a] = obwb_pkg::scale_t'($urandom_range(0, 16'hFFFF));
      else w.scale[a] = obwb_pkg::scale_t'($urandom_range(32, 1024));
      if ($urandom_range(0, 15) == 0) w.shift[a] = $urandom;
      else w.shift[a] = int'($urandom_range(0, 1 << 29)) - (1 << 28);
    end
    // occasionally hand the block inverted extents
    if ($urandom_range(0, 15) == 0) {w.box_min, w.box_max} = {w.box_max, w.box_min};
    if ($urandom_range(0, 15) == 0) begin
      w.quat = {$urandom, $urandom};
    end else begin
      norm = 0.0;
      for (a = 0; a < 4; a++) begin
        qv[a] = real'(int'($urandom_range(0, 2000)) - 1000);
        norm += qv[a] * qv[a];
      end
      norm = $sqrt(norm);
      if (norm == 0.0) begin
        qv[3] = 1.0;
        norm = 1.0;
      end
      for (a = 0; a < 4; a++) w.quat[a] = obwb_pkg::quat_t'($rtoi(qv[a] / norm * 32767.0));
    end
    return w;
  endfunction

  task automatic add_row(input box_word_t w, input bit typed, input bounds_t want);
    dir_row_t r;
    r.word  = w;
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endtask

  // Offer one word, starting at a falling edge; hold it until the block takes it.
  task automatic push_word(input box_word_t w, input bit typed, input bounds_t want);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= w;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bounds_due.push_back(typed ? want : world_bounds(w));
    words_sent++;
    @(negedge clk);
  endtask

  // Sink side: hold m_tready high, drop it for random bursts while idling is on.
  initial begin : sink_ready
    int stall_left;
    m_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 13);
      end
    end
  end

  // Compare every accepted result against the oldest prediction, field by field.
  always @(posedge clk) begin : check_words
    bounds_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = bounds_t'(m_tdata);
      if (bounds_due.size() == 0) begin
        report_mismatch("unexpected word", words_checked, got[0], '0);
      end else begin
        want = bounds_due.pop_front();
        for (int f = 0; f < 6; f++)
          if (got[f] !== want[f]) report_mismatch(field_name[f], words_checked, got[f], want[f]);
      end
      words_checked++;
    end
  end

  initial begin : stimulus
    int k;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    idle_on = 1'b1;
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words. Typed rows: all zero, zero scale (world = shift), identity, inverted
    // extents, negative scale, saturation both ways, half-LSB rounding, zero scale under a raw quaternion.
    add_row(box_word(0, 0, 0, 0, 0, 0, 48'h0, NO_QUAT, 0, 0, 0),
            1'b1, expect_bounds(0, 0, 0, 0, 0, 0));
    add_row(box_word(5*ONE, -ONE, 7, C_MAX, C_MIN, 3*ONE, 48'h0, NO_QUAT,
                     ONE, 2*ONE, -3*ONE),
            1'b1, expect_bounds(ONE, 2*ONE, -3*ONE, ONE, 2*ONE, -3*ONE));
    add_row(box_word(-ONE, -2*ONE, -3*ONE, 4*ONE, 5*ONE, 6*ONE, UNIT_SCALE, NO_QUAT, 0, 0, 0),
            1'b1, expect_bounds(-ONE, -2*ONE, -3*ONE, 4*ONE, 5*ONE, 6*ONE));
    add_row(box_word(4*ONE, 5*ONE, 6*ONE, -ONE, -2*ONE, -3*ONE, UNIT_SCALE, NO_QUAT, 0, 0, 0),
            1'b1, expect_bounds(-ONE, -2*ONE, -3*ONE, 4*ONE, 5*ONE, 6*ONE));
    add_row(box_word(ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, NEG_SCALE, NO_QUAT, 0, 0, 0),
            1'b1, expect_bounds(-4*ONE, -5*ONE, -6*ONE, -ONE, -2*ONE, -3*ONE));
    add_row(box_word(0, -ONE, 0, ONE, 0, 0, UNIT_SCALE, NO_QUAT, C_MAX, C_MIN, 0),
            1'b1, expect_bounds(C_MAX, C_MIN, 0, C_MAX, C_MIN, 0));
    add_row(box_word(-1, -1, -1, 1, 1, 1, HALF_SCALE, NO_QUAT, 0, 0, 0),
            1'b1, expect_bounds(0, 0, 0, 1, 1, 1));
    add_row(box_word(0, 0, 0, 0, 0, 0, 48'h0, 64'h1234_8765_ABCD_4321, C_MIN, C_MAX, C_MIN),
            1'b1, expect_bounds(C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN));
    // Predicted rows: quaternion extremes, non-unit quaternions, field extremes.
    add_row(box_word(-ONE, -ONE, -ONE, ONE, ONE, ONE, UNIT_SCALE, {16'h7FFF, 48'h0}, 0, 0, 0),
            1'b0, '0);
    add_row(box_word(-ONE, 0, -2*ONE, 3*ONE, ONE, 2*ONE, UNIT_SCALE, QUAT_Z90, ONE, 0, 0),
            1'b0, '0);
    add_row(box_word(-ONE, 0, -2*ONE, 3*ONE, ONE, 2*ONE, UNIT_SCALE, QUAT_X180, 0, ONE, 0),
            1'b0, '0);
    add_row(box_word(-ONE, -ONE, -ONE, ONE, ONE, ONE, UNIT_SCALE, {4{16'hFFFF}}, 0, 0, 0),
            1'b0, '0);
    add_row(box_word(-ONE, -ONE, -ONE, ONE, ONE, ONE, UNIT_SCALE, {4{16'h8000}}, 0, 0, 0),
            1'b0, '0);
    add_row(box_word(-ONE, -ONE, -ONE, ONE, ONE, ONE, UNIT_SCALE,
                     {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 0, 0, 0),
            1'b0, '0);
    add_row(box_word(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, {3{16'h7FFF}}, NO_QUAT, 0, 0, 0),
            1'b0, '0);
    add_row(box_word(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, {3{16'h8000}}, QUAT_Y90,
                     0, 0, 0),
            1'b0, '0);
    add_row(box_word(C_MIN, 0, C_MAX, C_MAX, ONE, C_MIN, UNIT_SCALE, QUAT_Z90,
                     C_MAX, C_MIN, C_MAX),
            1'b0, '0);
    add_row(box_word(-1, -1, -1, -1, -1, -1, '1, '1, -1, -1, -1), 1'b0, '0);
    add_row(box_word(-3*ONE, 7, -5, 2*ONE, 9*ONE, 11, {16'h0001, 16'h8000, 16'h7FFF},
                     QUAT_Y90, -ONE, ONE, 0),
            1'b0, '0);

    foreach (dir_rows[i]) push_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);

    // Random words: idling switches on and off in blocks, and stays off at the end.
    for (k = 0; k < RANDOM_WORDS; k++) begin
      idle_on = ((k / 120) % 3 != 1) && (k < RANDOM_WORDS - CALM_TAIL);
      push_word(random_word($urandom_range(0, 3) == 0), 1'b0, '0);
    end
    s_tvalid <= 1'b0;
    idle_on = 1'b0;

    // Drain, then give the six-stage pipe time to show any stray word.
    while (bounds_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("tb_top: %0d box words sent (%0d directed, rest random), %0d bound words checked",
             words_sent, dir_rows.size(), words_checked);
    $display("tb_top: %0d field mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/obwb_pkg.sv
rtl/core/obwb_axis.sv
rtl/core/oriented_box_world_bounds_top.sv
tb/tb_top.sv
